### src/qsv_pkg.sv
// shared types and constants for the quad shadow volume vertex block
`default_nettype none
package qsv_pkg;

  localparam int COORD_W     = 17;
  localparam int DIFF_W      = 18;
  localparam int PROD_W      = 36;
  localparam int SQ_W        = 34;
  localparam int LEN_W       = 35;
  localparam int RAD_W       = 16;
  localparam int R2_W        = 32;
  localparam int QUO_W       = 29;
  localparam int NUM_W       = SQ_W + QUO_W - 1;
  localparam int DSH_W       = LEN_W + QUO_W - 1;
  localparam int OP_W        = 30;
  localparam int ROOT_W      = 15;
  localparam int UNIT_FRAC   = 14;
  localparam int DIV_STEPS   = 29;
  localparam int SQRT_STEPS  = 15;
  localparam int STEP_W      = 5;
  localparam int NUM_CORNERS = 4;
  localparam int CIDX_W      = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int ALPHA_W     = 8;
  localparam int ALPHA_FULL  = 255;
  localparam int ALPHA_SQ    = ALPHA_FULL * ALPHA_FULL;
  localparam int X_W         = 48;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int EXT_W       = COORD_W + 2;
  localparam int OFFP_W      = ROOT_W + RAD_W;

  typedef enum logic [1:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_RADIUS,
    REG_SHADOW_LENGTH
  } reg_idx_t;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_DIV,
    LANE_SQRT,
    LANE_DONE
  } lane_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

  typedef struct packed {
    logic [NUM_CORNERS-1:0][COORD_W-1:0] cx;
    logic [NUM_CORNERS-1:0][COORD_W-1:0] cy;
    logic [NUM_CORNERS-1:0][SQ_W-1:0]    sqx;
    logic [NUM_CORNERS-1:0][SQ_W-1:0]    sqy;
    logic [NUM_CORNERS-1:0]              sgnx;
    logic [NUM_CORNERS-1:0]              sgny;
    logic [R2_W-1:0]                     d2;
  } job_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              inexact;
    logic              done;
  } lane_out_t;

endpackage
`default_nettype wire

### src/qsv_lane.sv
// iterative divide then square root lane: root of num/den, one bit per cycle
`default_nettype none
module qsv_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       ceil_mode,
  input  logic [qsv_pkg::NUM_W-1:0]  num,
  input  logic [qsv_pkg::LEN_W-1:0]  den,
  output qsv_pkg::lane_out_t         res
);

  qsv_pkg::lane_state_t state, state_next;

  logic [qsv_pkg::NUM_W-1:0]  rem;
  logic [qsv_pkg::DSH_W-1:0]  dsh;
  logic [qsv_pkg::QUO_W-1:0]  quo;
  logic [qsv_pkg::OP_W-1:0]   op;
  logic [qsv_pkg::OP_W-1:0]   acc;
  logic [qsv_pkg::OP_W-1:0]   one;
  logic [qsv_pkg::STEP_W-1:0] cnt;
  logic                       ceil_r;

  logic                       ge;
  logic [qsv_pkg::NUM_W-1:0]  rem_new;
  logic [qsv_pkg::QUO_W-1:0]  quo_new;
  logic [qsv_pkg::OP_W-1:0]   sum;
  logic                       sq_ge;
  logic                       div_last;
  logic                       sqrt_last;
  logic                       load;

  always_comb begin
    ge        = {{(qsv_pkg::DSH_W - qsv_pkg::NUM_W){1'b0}}, rem} >= dsh;
    rem_new   = ge ? rem - dsh[qsv_pkg::NUM_W-1:0] : rem;
    quo_new   = {quo[qsv_pkg::QUO_W-2:0], ge};
    sum       = acc + one;
    sq_ge     = op >= sum;
    div_last  = cnt == qsv_pkg::STEP_W'(qsv_pkg::DIV_STEPS - 1);
    sqrt_last = cnt == qsv_pkg::STEP_W'(qsv_pkg::SQRT_STEPS - 1);
    load      = start && (state == qsv_pkg::LANE_IDLE || state == qsv_pkg::LANE_DONE);
    state_next = state;
    case (state)
      qsv_pkg::LANE_IDLE, qsv_pkg::LANE_DONE: begin
        if (load) state_next = qsv_pkg::LANE_DIV;
      end
      qsv_pkg::LANE_DIV: begin
        if (div_last) state_next = qsv_pkg::LANE_SQRT;
      end
      qsv_pkg::LANE_SQRT: begin
        if (sqrt_last) state_next = qsv_pkg::LANE_DONE;
      end
      default: state_next = qsv_pkg::LANE_IDLE;
    endcase
    res.root    = acc[qsv_pkg::ROOT_W-1:0];
    res.inexact = op != '0;
    res.done    = state == qsv_pkg::LANE_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsv_pkg::LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem    <= num;
      dsh    <= {den, {(qsv_pkg::QUO_W - 1){1'b0}}};
      quo    <= '0;
      cnt    <= '0;
      ceil_r <= ceil_mode;
    end else if (state == qsv_pkg::LANE_DIV) begin
      rem <= rem_new;
      quo <= quo_new;
      dsh <= dsh >> 1;
      if (div_last) begin
        cnt <= '0;
        // ceiling divide when asked: bump quotient on a nonzero remainder
        op  <= qsv_pkg::OP_W'(quo_new) + qsv_pkg::OP_W'(ceil_r && rem_new != '0);
        acc <= '0;
        one <= qsv_pkg::OP_W'(1) << (2 * (qsv_pkg::SQRT_STEPS - 1));
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (state == qsv_pkg::LANE_SQRT) begin
      if (sq_ge) begin
        op  <= op - sum;
        acc <= (acc >> 1) + one;
      end else begin
        acc <= acc >> 1;
      end
      one <= one >> 2;
      cnt <= sqrt_last ? '0 : cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

### src/qsv_front.sv
// front: accepts blocks, squares light offsets, range test, queue push
`default_nettype none
module qsv_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qsv_pkg::COORD_W-1:0] ref_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] ref_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner0_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner0_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner1_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner1_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner2_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner2_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner3_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner3_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] light_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] light_y,
  input  logic        [qsv_pkg::RAD_W-1:0]   light_radius,
  input  logic        [qsv_pkg::QCNT_W-1:0]  q_count,
  output logic                               push,
  output qsv_pkg::job_t                      job
);

  logic                               s1_valid;
  logic signed [qsv_pkg::COORD_W-1:0] s1_rx;
  logic signed [qsv_pkg::COORD_W-1:0] s1_ry;
  logic signed [qsv_pkg::COORD_W-1:0] s1_cx [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::COORD_W-1:0] s1_cy [qsv_pkg::NUM_CORNERS];

  logic                               s2_valid;
  logic [qsv_pkg::LEN_W-1:0]          s2_d2;
  qsv_pkg::job_t                      s2_job;

  logic signed [qsv_pkg::DIFF_W-1:0]  dx, dy;
  logic signed [qsv_pkg::PROD_W-1:0]  px, py;
  logic signed [qsv_pkg::DIFF_W-1:0]  vx [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::DIFF_W-1:0]  vy [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::PROD_W-1:0]  pvx [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::PROD_W-1:0]  pvy [qsv_pkg::NUM_CORNERS];
  logic [qsv_pkg::R2_W-1:0]           r2;
  logic                               accept;

  // in-flight items hold a queue slot so a push never finds it full
  assign busy = (q_count + qsv_pkg::QCNT_W'(s1_valid) + qsv_pkg::QCNT_W'(s2_valid))
                >= qsv_pkg::QCNT_W'(qsv_pkg::QDEPTH);
  assign accept = start && !busy;

  always_comb begin
    dx = qsv_pkg::DIFF_W'(s1_rx) - qsv_pkg::DIFF_W'(light_x);
    dy = qsv_pkg::DIFF_W'(s1_ry) - qsv_pkg::DIFF_W'(light_y);
    px = dx * dx;
    py = dy * dy;
    for (int k = 0; k < qsv_pkg::NUM_CORNERS; k++) begin
      vx[k]  = qsv_pkg::DIFF_W'(s1_cx[k]) - qsv_pkg::DIFF_W'(light_x);
      vy[k]  = qsv_pkg::DIFF_W'(s1_cy[k]) - qsv_pkg::DIFF_W'(light_y);
      pvx[k] = vx[k] * vx[k];
      pvy[k] = vy[k] * vy[k];
    end
    r2   = light_radius * light_radius;
    push = s2_valid && (s2_d2 <= qsv_pkg::LEN_W'(r2));
    job  = s2_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rx    <= ref_x;
      s1_ry    <= ref_y;
      s1_cx[0] <= corner0_x;
      s1_cy[0] <= corner0_y;
      s1_cx[1] <= corner1_x;
      s1_cy[1] <= corner1_y;
      s1_cx[2] <= corner2_x;
      s1_cy[2] <= corner2_y;
      s1_cx[3] <= corner3_x;
      s1_cy[3] <= corner3_y;
    end
    s2_d2     <= qsv_pkg::LEN_W'(px[qsv_pkg::SQ_W-1:0]) + qsv_pkg::LEN_W'(py[qsv_pkg::SQ_W-1:0]);
    s2_job.d2 <= qsv_pkg::R2_W'(px[qsv_pkg::SQ_W-1:0] + py[qsv_pkg::SQ_W-1:0]);
    for (int k = 0; k < qsv_pkg::NUM_CORNERS; k++) begin
      s2_job.cx[k]   <= s1_cx[k];
      s2_job.cy[k]   <= s1_cy[k];
      s2_job.sqx[k]  <= pvx[k][qsv_pkg::SQ_W-1:0];
      s2_job.sqy[k]  <= pvy[k][qsv_pkg::SQ_W-1:0];
      s2_job.sgnx[k] <= vx[k][qsv_pkg::DIFF_W-1];
      s2_job.sgny[k] <= vy[k][qsv_pkg::DIFF_W-1];
    end
  end

endmodule
`default_nettype wire

### src/qsv_queue.sv
// short job queue between front and back
`default_nettype none
module qsv_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  qsv_pkg::job_t                     wr_job,
  input  logic                              pop,
  output qsv_pkg::job_t                     head,
  output logic [qsv_pkg::QCNT_W-1:0]        count
);

  qsv_pkg::job_t                 mem [qsv_pkg::QDEPTH];
  logic [qsv_pkg::QPTR_W-1:0]    wr_ptr;
  logic [qsv_pkg::QPTR_W-1:0]    rd_ptr;

  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + qsv_pkg::QCNT_W'(push) - qsv_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

endmodule
`default_nettype wire

### src/qsv_back.sv
// back: alpha and unit direction solve, extrusion, vertex sequencing
`default_nettype none
module qsv_back (
  input  logic                               clk,
  input  logic                               rst,
  input  qsv_pkg::job_t                      head,
  input  logic [qsv_pkg::QCNT_W-1:0]         q_count,
  output logic                               pop,
  input  logic [qsv_pkg::RAD_W-1:0]          light_radius,
  input  logic [qsv_pkg::RAD_W-1:0]          shadow_length,
  output logic                               vertex_valid,
  output logic signed [qsv_pkg::COORD_W-1:0] vertex_x,
  output logic signed [qsv_pkg::COORD_W-1:0] vertex_y,
  output logic [qsv_pkg::ALPHA_W-1:0]        vertex_alpha,
  output logic                               last_vertex
);

  qsv_pkg::back_state_t state, state_next;

  qsv_pkg::lane_out_t lx [qsv_pkg::NUM_CORNERS];
  qsv_pkg::lane_out_t ly [qsv_pkg::NUM_CORNERS];
  qsv_pkg::lane_out_t la;

  logic [qsv_pkg::R2_W-1:0]  r2;
  logic [qsv_pkg::X_W-1:0]   xnum;
  logic                      all_done;
  logic                      em_free;
  logic                      load_em;

  logic signed [qsv_pkg::COORD_W-1:0] b_cx [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::COORD_W-1:0] b_cy [qsv_pkg::NUM_CORNERS];
  logic [qsv_pkg::NUM_CORNERS-1:0]    b_sgnx, b_sgny, b_zero;
  logic                               b_r2zero;

  logic signed [qsv_pkg::COORD_W-1:0] ex [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::COORD_W-1:0] ey [qsv_pkg::NUM_CORNERS];
  logic [qsv_pkg::ALPHA_W-1:0]        alpha;
  logic [qsv_pkg::ROOT_W:0]           t_alpha;

  logic                               em_active;
  logic [3:0]                         em_cnt;
  logic signed [qsv_pkg::COORD_W-1:0] em_cx [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::COORD_W-1:0] em_cy [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::COORD_W-1:0] em_ex [qsv_pkg::NUM_CORNERS];
  logic signed [qsv_pkg::COORD_W-1:0] em_ey [qsv_pkg::NUM_CORNERS];
  logic [qsv_pkg::ALPHA_W-1:0]        em_alpha;
  logic [qsv_pkg::CIDX_W-1:0]         cidx;
  logic                               use_ext;

  function automatic logic signed [qsv_pkg::COORD_W-1:0] push_coord(
    input logic signed [qsv_pkg::COORD_W-1:0] c,
    input logic [qsv_pkg::ROOT_W-1:0]         u,
    input logic                               neg,
    input logic [qsv_pkg::RAD_W-1:0]          len
  );
    logic [qsv_pkg::OFFP_W-1:0]       prod;
    logic signed [qsv_pkg::EXT_W-1:0] off;
    logic signed [qsv_pkg::EXT_W-1:0] e;
    logic signed [qsv_pkg::COORD_W-1:0] r;
    prod = u * len;
    off  = qsv_pkg::EXT_W'(prod[qsv_pkg::OFFP_W-1:qsv_pkg::UNIT_FRAC]);
    e    = neg ? qsv_pkg::EXT_W'(c) - off : qsv_pkg::EXT_W'(c) + off;
    if (e > qsv_pkg::EXT_W'(2 ** (qsv_pkg::COORD_W - 1) - 1)) begin
      r = {1'b0, {(qsv_pkg::COORD_W - 1){1'b1}}};
    end else if (e < -qsv_pkg::EXT_W'(2 ** (qsv_pkg::COORD_W - 1))) begin
      r = {1'b1, {(qsv_pkg::COORD_W - 1){1'b0}}};
    end else begin
      r = e[qsv_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  assign r2   = light_radius * light_radius;
  assign xnum = qsv_pkg::X_W'(head.d2) * qsv_pkg::X_W'(qsv_pkg::ALPHA_SQ);

  // alpha = 255 - ceil(sqrt(ceil(255^2 * d2 / r2)))
  qsv_lane u_alpha (
    .clk       (clk),
    .rst       (rst),
    .start     (pop),
    .ceil_mode (1'b1),
    .num       (qsv_pkg::NUM_W'(xnum)),
    .den       (qsv_pkg::LEN_W'(r2)),
    .res       (la)
  );

  for (genvar k = 0; k < qsv_pkg::NUM_CORNERS; k++) begin : g_dir
    logic [qsv_pkg::LEN_W-1:0] len2;
    assign len2 = qsv_pkg::LEN_W'(head.sqx[k]) + qsv_pkg::LEN_W'(head.sqy[k]);

    qsv_lane u_x (
      .clk       (clk),
      .rst       (rst),
      .start     (pop),
      .ceil_mode (1'b0),
      .num       ({head.sqx[k], {(qsv_pkg::QUO_W - 1){1'b0}}}),
      .den       (len2),
      .res       (lx[k])
    );

    qsv_lane u_y (
      .clk       (clk),
      .rst       (rst),
      .start     (pop),
      .ceil_mode (1'b0),
      .num       ({head.sqy[k], {(qsv_pkg::QUO_W - 1){1'b0}}}),
      .den       (len2),
      .res       (ly[k])
    );

    always_ff @(posedge clk) begin
      if (pop) begin
        b_cx[k]   <= head.cx[k];
        b_cy[k]   <= head.cy[k];
        b_sgnx[k] <= head.sgnx[k];
        b_sgny[k] <= head.sgny[k];
        b_zero[k] <= len2 == '0;
      end
    end
  end

  always_comb begin
    all_done = la.done;
    for (int k = 0; k < qsv_pkg::NUM_CORNERS; k++) begin
      all_done = all_done && lx[k].done && ly[k].done;
      if (b_zero[k]) begin
        ex[k] = b_cx[k];
        ey[k] = b_cy[k];
      end else begin
        ex[k] = push_coord(b_cx[k], lx[k].root, b_sgnx[k], shadow_length);
        ey[k] = push_coord(b_cy[k], ly[k].root, b_sgny[k], shadow_length);
      end
    end
    t_alpha = (qsv_pkg::ROOT_W + 1)'(la.root) + (qsv_pkg::ROOT_W + 1)'(la.inexact);
    // zero radius is only in range on the light itself
    alpha = b_r2zero ? qsv_pkg::ALPHA_W'(qsv_pkg::ALPHA_FULL)
                     : qsv_pkg::ALPHA_W'((qsv_pkg::ROOT_W + 1)'(qsv_pkg::ALPHA_FULL) - t_alpha);

    em_free = !em_active || em_cnt == 4'd15;
    pop     = 1'b0;
    load_em = 1'b0;
    state_next = state;
    case (state)
      qsv_pkg::BACK_IDLE: begin
        if (q_count != '0) begin
          pop        = 1'b1;
          state_next = qsv_pkg::BACK_RUN;
        end
      end
      qsv_pkg::BACK_RUN: begin
        if (all_done && em_free) begin
          load_em    = 1'b1;
          state_next = qsv_pkg::BACK_IDLE;
        end
      end
      default: state_next = qsv_pkg::BACK_IDLE;
    endcase

    // per edge: corner i, extruded i, extruded i+1, corner i+1
    cidx    = em_cnt[1] ? em_cnt[3:2] + 1'b1 : em_cnt[3:2];
    use_ext = em_cnt[1] ^ em_cnt[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsv_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b_r2zero <= r2 == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_active    <= 1'b0;
      em_cnt       <= '0;
      vertex_valid <= 1'b0;
    end else begin
      vertex_valid <= em_active;
      if (load_em) begin
        em_active <= 1'b1;
        em_cnt    <= '0;
      end else if (em_active) begin
        em_cnt <= em_cnt + 1'b1;
        if (em_cnt == 4'd15) em_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_em) begin
      em_alpha <= alpha;
      for (int k = 0; k < qsv_pkg::NUM_CORNERS; k++) begin
        em_cx[k] <= b_cx[k];
        em_cy[k] <= b_cy[k];
        em_ex[k] <= ex[k];
        em_ey[k] <= ey[k];
      end
    end
    vertex_x     <= use_ext ? em_ex[cidx] : em_cx[cidx];
    vertex_y     <= use_ext ? em_ey[cidx] : em_cy[cidx];
    vertex_alpha <= use_ext ? '0 : em_alpha;
    last_vertex  <= em_cnt == 4'd15;
  end

endmodule
`default_nettype wire

### src/quad_shadow_volume_vertices.sv
// top level: configuration registers, front, job queue and back
// a block's 16 vertices come out on consecutive cycles
// the block rate is set by the bit-serial divide and root lanes, which solve one block at a time
// (29 quotient steps plus 15 root steps); emission of one block overlaps the next solve
// blocks out of light range are dropped by the range test in the front and produce no vertices
// synchronous reset clears control state and loads the register defaults
`default_nettype none
module quad_shadow_volume_vertices (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qsv_pkg::COORD_W-1:0] ref_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] ref_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner0_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner0_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner1_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner1_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner2_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner2_y,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner3_x,
  input  logic signed [qsv_pkg::COORD_W-1:0] corner3_y,
  output logic                               vertex_valid,
  output logic signed [qsv_pkg::COORD_W-1:0] vertex_x,
  output logic signed [qsv_pkg::COORD_W-1:0] vertex_y,
  output logic [qsv_pkg::ALPHA_W-1:0]        vertex_alpha,
  output logic                               last_vertex,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qsv_pkg::ADDR_W-1:0]         paddr,
  input  logic [qsv_pkg::DATA_W-1:0]         pwdata,
  output logic [qsv_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic signed [qsv_pkg::COORD_W-1:0] light_x;
  logic signed [qsv_pkg::COORD_W-1:0] light_y;
  logic [qsv_pkg::RAD_W-1:0]          light_radius;
  logic [qsv_pkg::RAD_W-1:0]          shadow_length;

  logic                               push;
  logic                               pop;
  qsv_pkg::job_t                      wr_job;
  qsv_pkg::job_t                      head;
  logic [qsv_pkg::QCNT_W-1:0]         q_count;
  qsv_pkg::reg_idx_t                  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = qsv_pkg::reg_idx_t'(paddr[qsv_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x       <= '0;
      light_y       <= '0;
      light_radius  <= qsv_pkg::RAD_W'(3200);
      shadow_length <= qsv_pkg::RAD_W'(1600);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        qsv_pkg::REG_LIGHT_X:       light_x       <= pwdata[qsv_pkg::COORD_W-1:0];
        qsv_pkg::REG_LIGHT_Y:       light_y       <= pwdata[qsv_pkg::COORD_W-1:0];
        qsv_pkg::REG_LIGHT_RADIUS:  light_radius  <= pwdata[qsv_pkg::RAD_W-1:0];
        qsv_pkg::REG_SHADOW_LENGTH: shadow_length <= pwdata[qsv_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qsv_pkg::REG_LIGHT_X:       prdata = qsv_pkg::DATA_W'(light_x);
      qsv_pkg::REG_LIGHT_Y:       prdata = qsv_pkg::DATA_W'(light_y);
      qsv_pkg::REG_LIGHT_RADIUS:  prdata = qsv_pkg::DATA_W'(light_radius);
      qsv_pkg::REG_SHADOW_LENGTH: prdata = qsv_pkg::DATA_W'(shadow_length);
      default:                    prdata = '0;
    endcase
  end

  qsv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .ref_x        (ref_x),
    .ref_y        (ref_y),
    .corner0_x    (corner0_x),
    .corner0_y    (corner0_y),
    .corner1_x    (corner1_x),
    .corner1_y    (corner1_y),
    .corner2_x    (corner2_x),
    .corner2_y    (corner2_y),
    .corner3_x    (corner3_x),
    .corner3_y    (corner3_y),
    .light_x      (light_x),
    .light_y      (light_y),
    .light_radius (light_radius),
    .q_count      (q_count),
    .push         (push),
    .job          (wr_job)
  );

  qsv_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .count  (q_count)
  );

  qsv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_count       (q_count),
    .pop           (pop),
    .light_radius  (light_radius),
    .shadow_length (shadow_length),
    .vertex_valid  (vertex_valid),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_alpha  (vertex_alpha),
    .last_vertex   (last_vertex)
  );

endmodule
`default_nettype wire

### bench/tb_quad_shadow_volume_vertices.sv
// testbench for the quad shadow volume vertex block: predicts every vertex and checks it
`timescale 1ns / 100ps
module tb_quad_shadow_volume_vertices;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [7:0]         alpha;
    logic               last;
  } vertex_t;

  typedef struct {
    logic signed [16:0] rx, ry;
    logic signed [16:0] cx[4];
    logic signed [16:0] cy[4];
  } quad_t;

  logic clk = 0, rst = 1, start = 0;
  logic busy;
  logic signed [16:0] ref_x = 0, ref_y = 0;
  logic signed [16:0] corner0_x = 0, corner0_y = 0, corner1_x = 0, corner1_y = 0;
  logic signed [16:0] corner2_x = 0, corner2_y = 0, corner3_x = 0, corner3_y = 0;
  logic vertex_valid;
  logic signed [16:0] vertex_x, vertex_y;
  logic [7:0] vertex_alpha;
  logic last_vertex;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [qsv_pkg::ADDR_W-1:0] paddr = 0;
  logic [qsv_pkg::DATA_W-1:0] pwdata = 0;
  logic [qsv_pkg::DATA_W-1:0] prdata;
  logic pready;

  quad_shadow_volume_vertices uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // shadow copy of the registers
  longint lx = 0, ly = 0, lrad = 3200, slen = 1600;
  vertex_t pending_vertices[$];
  int errors = 0, n_blocks = 0, n_lit = 0, n_vertices = 0;
  int send_idle = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch: %s got %0d want %0d (vertex %0d)", what, got, want, n_vertices);
  endtask

  task automatic add_vertex(input vertex_t v);
    pending_vertices.insert(pending_vertices.size(), v);
  endtask

  function automatic longint unit_part(longint c, longint len2);
    longint mag, num, lo, hi, mid;
    mag = c < 0 ? -c : c;
    num = mag * mag * (longint'(1) << 28);
    lo = 0; hi = longint'(1) << 14;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid * len2 <= num) lo = mid; else hi = mid - 1;
    end
    return c < 0 ? -lo : lo;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint pushed(longint c, longint u);
    longint mag, off;
    mag = u < 0 ? -u : u;
    off = (mag * slen) >>> 14;
    return clamp_coord(c + (u < 0 ? -off : off));
  endfunction

  task automatic predict_vertices(input quad_t q);
    longint dx, dy, d2, a, rhs, vx, vy, len2;
    longint cx[4], cy[4], ex[4], ey[4];
    vertex_t v;
    int j;
    dx = longint'(q.rx) - lx;
    dy = longint'(q.ry) - ly;
    d2 = dx * dx + dy * dy;
    if (d2 > lrad * lrad) return;
    n_lit++;
    a = 0;
    for (int i = 255; i >= 0; i--) begin
      rhs = longint'(255 - i) * lrad;
      if (65025 * d2 <= rhs * rhs) begin
        a = i;
        break;
      end
    end
    for (int i = 0; i < 4; i++) begin
      cx[i] = longint'(q.cx[i]); cy[i] = longint'(q.cy[i]);
      vx = cx[i] - lx; vy = cy[i] - ly;
      len2 = vx * vx + vy * vy;
      if (len2 == 0) begin
        ex[i] = cx[i]; ey[i] = cy[i];
      end else begin
        ex[i] = pushed(cx[i], unit_part(vx, len2));
        ey[i] = pushed(cy[i], unit_part(vy, len2));
      end
    end
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      v.x = 17'(cx[i]); v.y = 17'(cy[i]); v.alpha = 8'(a); v.last = 1'b0;
      add_vertex(v);
      v.x = 17'(ex[i]); v.y = 17'(ey[i]); v.alpha = 8'd0;
      add_vertex(v);
      v.x = 17'(ex[j]); v.y = 17'(ey[j]);
      add_vertex(v);
      v.x = 17'(cx[j]); v.y = 17'(cy[j]); v.alpha = 8'(a); v.last = (i == 3);
      add_vertex(v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && vertex_valid) begin
      vertex_t w;
      n_vertices++;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected vertex x", vertex_x, 0);
      end else begin
        w = pending_vertices.pop_front();
        if (vertex_x !== w.x) report_mismatch("vertex_x", vertex_x, w.x);
        if (vertex_y !== w.y) report_mismatch("vertex_y", vertex_y, w.y);
        if (vertex_alpha !== w.alpha) report_mismatch("vertex_alpha", vertex_alpha, w.alpha);
        if (last_vertex !== w.last) report_mismatch("last_vertex", last_vertex, w.last);
      end
    end
  end

  task automatic send_quad(input quad_t q);
    while ($urandom_range(99) < send_idle) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    ref_x <= q.rx; ref_y <= q.ry;
    corner0_x <= q.cx[0]; corner0_y <= q.cy[0]; corner1_x <= q.cx[1]; corner1_y <= q.cy[1];
    corner2_x <= q.cx[2]; corner2_y <= q.cy[2]; corner3_x <= q.cx[3]; corner3_y <= q.cy[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_vertices(q);
    n_blocks++;
  endtask

  task automatic drain;
    start <= 0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input qsv_pkg::reg_idx_t idx, input longint value);
    drain();
    psel <= 1; pwrite <= 1; paddr <= qsv_pkg::ADDR_W'(4 * idx);
    pwdata <= qsv_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      qsv_pkg::REG_LIGHT_X:       lx = longint'(signed'(value[16:0]));
      qsv_pkg::REG_LIGHT_Y:       ly = longint'(signed'(value[16:0]));
      qsv_pkg::REG_LIGHT_RADIUS:  lrad = value & 16'hFFFF;
      qsv_pkg::REG_SHADOW_LENGTH: slen = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  function automatic logic signed [16:0] rand_coord();
    return $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(4000)) - 17'sd2000;
  endfunction

  function automatic quad_t rand_quad(input int near);
    quad_t q;
    logic signed [16:0] bx, by;
    bx = rand_coord(); by = rand_coord();
    if (near) begin
      bx = 17'(lx) + 17'($urandom_range(600)) - 17'sd300;
      by = 17'(ly) + 17'($urandom_range(600)) - 17'sd300;
    end
    q.rx = bx; q.ry = by;
    for (int i = 0; i < 4; i++) begin
      q.cx[i] = $urandom_range(4) == 0 ? 17'($urandom) : bx + 17'($urandom_range(400)) - 17'sd200;
      q.cy[i] = $urandom_range(4) == 0 ? 17'($urandom) : by + 17'($urandom_range(400)) - 17'sd200;
    end
    return q;
  endfunction

  task automatic test_directed;
    quad_t q;
    q.rx = 0; q.ry = 0;
    q.cx = '{0, 160, 160, 0}; q.cy = '{0, 0, 160, 160};
    send_quad(q);                                   // corner on the light
    q.rx = 3200; send_quad(q);                      // exactly on the radius
    q.rx = 3201; send_quad(q);                      // just out of range
    q.rx = 0;
    q.cx = '{65535, -65536, 65535, -65536}; q.cy = '{65535, 65535, -65536, -65536};
    send_quad(q);                                   // extrusion saturates
    q.cx = '{-1, 1, 17'h0AAAA, 17'h15555}; q.cy = '{17'h15555, 17'h0AAAA, 1, -1};
    send_quad(q);
    q.rx = -65536; q.ry = 65535; send_quad(q);
    write_reg(qsv_pkg::REG_LIGHT_RADIUS, 0);        // zero radius
    q.rx = 0; q.ry = 0; send_quad(q);
    q.rx = 1; send_quad(q);
    write_reg(qsv_pkg::REG_LIGHT_RADIUS, 65535);
    write_reg(qsv_pkg::REG_SHADOW_LENGTH, 65535);
    write_reg(qsv_pkg::REG_LIGHT_X, -65536);
    write_reg(qsv_pkg::REG_LIGHT_Y, 65535);
    q.rx = -65536; q.ry = 65535; send_quad(q);
    q.rx = 0; q.ry = 0; send_quad(q);
    write_reg(qsv_pkg::REG_SHADOW_LENGTH, 0);
    send_quad(q);
  endtask

  task automatic test_random_phase(input longint x, input longint y, input longint r,
                                   input longint s, input int items);
    write_reg(qsv_pkg::REG_LIGHT_X, x);
    write_reg(qsv_pkg::REG_LIGHT_Y, y);
    write_reg(qsv_pkg::REG_LIGHT_RADIUS, r);
    write_reg(qsv_pkg::REG_SHADOW_LENGTH, s);
    for (int i = 0; i < items; i++) send_quad(rand_quad($urandom_range(9) < 8));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle = 12;
    test_directed();
    test_random_phase(0, 0, 3200, 1600, 120);
    send_idle = 66;
    test_random_phase(17'h1FFFF & $urandom, 17'h1FFFF & $urandom, $urandom_range(65535),
                      $urandom_range(65535), 120);
    send_idle = 0;
    test_random_phase(-300, 700, 400, 65535, 120);
    test_random_phase(65535, -65536, 65535, 1, 120);
    drain();
    $display("covered %0d blocks, %0d in range, %0d vertices checked", n_blocks, n_lit,
             n_vertices);
    $display("register settings included zero and full radius and shadow length");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
